// ===== rtl/rkfd_pkg.sv =====
package rkfd_pkg;

	localparam int FRAME_BYTES = 8;

	// configuration register indexes
	localparam logic [1:0] REG_SYNC_BYTE    = 2'd0;
	localparam logic [1:0] REG_FIRST_REPEAT = 2'd1;
	localparam logic [1:0] REG_REPEAT_PER   = 2'd2;
	localparam logic [1:0] REG_REPEAT_MASK  = 2'd3;

	// reset values of the configuration registers
	localparam logic [7:0]  SYNC_BYTE_RST    = 8'd116;
	localparam logic [15:0] FIRST_REPEAT_RST = 16'd80;
	localparam logic [15:0] REPEAT_PER_RST   = 16'd12;
	localparam logic [15:0] REPEAT_MASK_RST  = 16'd952;

	// what the frame assembler reports for the byte it consumes
	typedef struct packed {
		logic        restart;    // bad sync byte or end of frame
		logic        frame_ok;   // end of frame with a good sum
		logic [7:0]  press_cnt;
		logic [7:0]  key_code;
		logic [23:0] device_id;
		logic [7:0]  battery;
	} frame_res_t;

	// key event decision
	typedef struct packed {
		logic key_ev;
		logic is_rep;
	} key_dec_t;

endpackage

// ===== rtl/remote_key_frame_decoder_unit.sv =====
// flow: an input transaction is held in the input register, its result in the result register,
// which offers it on the master side; stalls on the master side hold both registers
// throughput: one input transaction per cycle unless the master side stalls, set by the
// combinational sum and countdown path between the input register and the result register
// bytes in mid-frame and ticks give no result; the rest give exactly one
// reset: arst_n clears control state and loads the register defaults, frame bytes stay as they are
module remote_key_frame_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte
	input  logic [0:0]  s_tuser,   // func (1 = time tick)
	// master side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // device_id, battery, key_code, restart_receiver, zero pad
	output logic [1:0]  m_tuser,   // key_event, is_repeat
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	// configuration registers
	logic [7:0]  sync_byte_q;
	logic [15:0] first_ticks_q;
	logic [15:0] period_ticks_q;
	logic [15:0] key_mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_byte_q    <= rkfd_pkg::SYNC_BYTE_RST;
			first_ticks_q  <= rkfd_pkg::FIRST_REPEAT_RST;
			period_ticks_q <= rkfd_pkg::REPEAT_PER_RST;
			key_mask_q     <= rkfd_pkg::REPEAT_MASK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rkfd_pkg::REG_SYNC_BYTE:    sync_byte_q    <= cfg_wdata[7:0];
				rkfd_pkg::REG_FIRST_REPEAT: first_ticks_q  <= cfg_wdata;
				rkfd_pkg::REG_REPEAT_PER:   period_ticks_q <= cfg_wdata;
				rkfd_pkg::REG_REPEAT_MASK:  key_mask_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input register: holds one transaction while the result register is full and not taken
	logic       vld_s1;
	logic       tick_s1;
	logic [7:0] byte_s1;
	logic       advance;    // the result register can take what stage one produces

	assign advance  = !m_tvalid || m_tready;
	assign s_tready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (s_tready)
			vld_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			tick_s1 <= s_tuser[0];
			byte_s1 <= s_tdata;
		end
	end

	// stage one is consumed when it holds a transaction and the output can move
	logic step_byte, step_tick;
	assign step_byte = vld_s1 && advance && !tick_s1;
	assign step_tick = vld_s1 && advance && tick_s1;

	rkfd_pkg::frame_res_t fres;
	rkfd_pkg::key_dec_t   kdec;

	// frame assembly: sync check, running sum, byte store
	rkfd_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step_byte),
		.rx_byte   (byte_s1),
		.sync_byte (sync_byte_q),
		.res       (fres)
	);

	// press counter tracking and auto-repeat countdown
	rkfd_repeat u_repeat (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick         (step_tick),
		.frame_ok     (step_byte && fres.frame_ok),
		.press_cnt    (fres.press_cnt),
		.key_code     (fres.key_code),
		.first_ticks  (first_ticks_q),
		.period_ticks (period_ticks_q),
		.key_mask     (key_mask_q),
		.dec          (kdec)
	);

	// result register
	logic        out_vld_q;
	logic [47:0] out_data_q;
	logic [1:0]  out_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (advance)
			out_vld_q <= step_byte && fres.restart;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			// event fields read as zero when no key event goes out
			out_data_q <= {7'd0, 1'b1,
				kdec.key_ev ? fres.key_code : 8'd0,
				kdec.key_ev ? fres.battery : 8'd0,
				kdec.key_ev ? fres.device_id : 24'd0};
			out_user_q <= {kdec.is_rep, kdec.key_ev};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

// ===== rtl/rkfd_frame.sv =====
module rkfd_frame (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             rx_byte,
	input  logic [7:0]             sync_byte,
	output rkfd_pkg::frame_res_t   res
);

	localparam logic [2:0] LAST_POS = 3'(rkfd_pkg::FRAME_BYTES - 1);

	logic [2:0] pos_q;
	logic [7:0] sum_q;
	// bytes 1 to 6 are the only ones read back
	logic [7:0] store_q [1:6];

	logic first, last, bad_sync;

	always_comb begin
		first    = (pos_q == 3'd0);
		last     = (pos_q == LAST_POS);
		bad_sync = first && (rx_byte != sync_byte);

		res.restart   = bad_sync || last;
		res.frame_ok  = last && (rx_byte == sum_q);
		res.press_cnt = store_q[5];
		res.key_code  = store_q[6];
		res.device_id = {store_q[3], store_q[2], store_q[1]};
		res.battery   = store_q[4];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
		end else if (step && !bad_sync) begin
			if (last) begin
				pos_q <= '0;
				sum_q <= '0;
			end else begin
				pos_q <= pos_q + 3'd1;
				sum_q <= first ? rx_byte : sum_q + rx_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 1; i <= 6; i++) begin
			if (step && (pos_q == 3'(i)))
				store_q[i] <= rx_byte;
		end
	end

endmodule

// ===== rtl/rkfd_repeat.sv =====
module rkfd_repeat (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tick,
	input  logic                 frame_ok,
	input  logic [7:0]           press_cnt,
	input  logic [7:0]           key_code,
	input  logic [15:0]          first_ticks,
	input  logic [15:0]          period_ticks,
	input  logic [15:0]          key_mask,
	output rkfd_pkg::key_dec_t   dec
);

	logic [7:0]  prior_cnt_q;
	logic        prior_vld_q;
	logic        armed_q;
	logic [15:0] cnt_down_q;

	logic new_press, in_mask, due;

	always_comb begin
		new_press  = !prior_vld_q || (press_cnt != prior_cnt_q);
		in_mask    = (key_code[7:4] == 4'd0) && key_mask[key_code[3:0]];
		due        = armed_q && (cnt_down_q == 16'd0);
		dec.key_ev = frame_ok && (new_press || due);
		dec.is_rep = frame_ok && !new_press && due;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_cnt_q <= '0;
			prior_vld_q <= 1'b0;
			armed_q     <= 1'b0;
			cnt_down_q  <= '0;
		end else if (tick) begin
			if (armed_q && (cnt_down_q != 16'd0))
				cnt_down_q <= cnt_down_q - 16'd1;
		end else if (frame_ok) begin
			if (new_press) begin
				prior_cnt_q <= press_cnt;
				prior_vld_q <= 1'b1;
				armed_q     <= in_mask;
				cnt_down_q  <= in_mask ? first_ticks : 16'd0;
			end else if (due) begin
				cnt_down_q <= period_ticks;
			end
		end
	end

endmodule

// ===== rtl/rkfd_checker.sv =====
module rkfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// a repeat is always a key event
	a_rep_ev: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tuser[0])
		else $error("repeat flag without key event");

	// every result asks for a receiver restart
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[40])
		else $error("result without restart request");

	// no key event means zero event fields and zero pad
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> (m_tdata[39:0] == 40'd0) && (m_tdata[47:41] == 7'd0))
		else $error("event fields set without key event");

endmodule

bind remote_key_frame_decoder_unit rkfd_checker u_rkfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
